// ----- rtl/core/md5_pkg.sv -----
// Shared types, constants and round tables for the MD5 digest unit.
`timescale 1ns / 1ps

package md5_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [31:0] word_t;
  typedef logic [1:0]  widx_t;
  typedef logic [5:0]  step_t;

  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned BLOCK_BYTES = 64;

  // Chaining values loaded at reset and after every digest
  localparam word_t INIT_A = 32'h67452301;
  localparam word_t INIT_B = 32'hefcdab89;
  localparam word_t INIT_C = 32'h98badcfe;
  localparam word_t INIT_D = 32'h10325476;

  localparam byte_t PAD_BYTE = 8'h80;
  // First byte position that leaves no room for the length words
  localparam step_t LEN_POS = 6'd56;

  // Additive constant for each of the 64 steps
  function automatic word_t md5_k(input step_t i);
    word_t k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Rotate amount, indexed by {round, step[1:0]}
  function automatic logic [4:0] md5_rot(input logic [3:0] idx);
    logic [4:0] r;
    case (idx)
      4'd0:  r = 5'd7;   4'd1:  r = 5'd12;  4'd2:  r = 5'd17;  4'd3:  r = 5'd22;
      4'd4:  r = 5'd5;   4'd5:  r = 5'd9;   4'd6:  r = 5'd14;  4'd7:  r = 5'd20;
      4'd8:  r = 5'd4;   4'd9:  r = 5'd11;  4'd10: r = 5'd16;  4'd11: r = 5'd23;
      4'd12: r = 5'd6;   4'd13: r = 5'd10;  4'd14: r = 5'd15;  4'd15: r = 5'd21;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic word_t rotl32(input word_t x, input logic [4:0] n);
    logic [5:0] inv;
    inv = 6'd32 - {1'b0, n};
    return (x << n) | (x >> inv);
  endfunction

endpackage

// ----- rtl/core/md5_message_digest_unit.sv -----
// MD5 digest unit: byte packer, padding and a shared one-step compression datapath.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready): one message byte per transaction.
//   in_byte_valid=0 carries no byte; in_msg_last=1 ends the message and starts
//   padding and the final compression(s).
//   Output channel (out_valid/out_ready): four transactions per message, words
//   A, B, C, D (out_word_index 0..3), out_digest_last on D.
//   Throughput: bytes that do not close a block are taken one per cycle while
//   in_ready is high. A full block then runs the work load, 64 steps through
//   the single round datapath and the chaining add. After the last item: a
//   padding step, one or two compressions, then the four digest words, one
//   per cycle while the receiver takes them. No byte is taken during a compression.
//   in_ready is low whenever a compression, padding or digest output is in
//   progress; a stalled receiver holds the unit in digest output.
//   Reset loads the MD5 initial chaining values and clears the bit count and
//   fill position; after the D word is taken the unit re-arms the same way.
module md5_message_digest_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  md5_pkg::byte_t     in_data_byte,
  input  logic               in_byte_valid,
  input  logic               in_msg_last,
  output logic               out_valid,
  input  logic               out_ready,
  output md5_pkg::word_t     out_digest_word,
  output md5_pkg::widx_t     out_word_index,
  output logic               out_digest_last
);
  import md5_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_COMP = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_PAD  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]  state_r, state_nxt;
  step_t       step_r, step_nxt;
  word_t       chain_r [4];
  word_t       chain_nxt [4];
  word_t       work_r [4];
  word_t       work_nxt [4];
  word_t       blk_r [BLOCK_WORDS];
  word_t       blk_nxt [BLOCK_WORDS];
  logic [63:0] bitcnt_r, bitcnt_nxt;
  step_t       fill_r, fill_nxt;
  logic        last_r, last_nxt;   // padding still owed after this block
  logic        len_r, len_nxt;     // separate length block still owed
  logic        final_r, final_nxt; // current compression is the last one
  widx_t       idx_r, idx_nxt;

  // Round datapath signals
  logic [1:0]  rnd;
  logic [3:0]  g;
  word_t       fa, fb, fc, fd, f, sum, rot;

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = (state_r == ST_OUT);
  assign out_digest_word = chain_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_digest_last = (idx_r == 2'd3);

  // One MD5 step per cycle
  always_comb begin
    rnd = step_r[5:4];
    fa  = work_r[0];
    fb  = work_r[1];
    fc  = work_r[2];
    fd  = work_r[3];
    case (rnd)
      2'd0: begin
        f = (fb & fc) | (~fb & fd);
        g = step_r[3:0];
      end
      2'd1: begin
        f = (fb & fd) | (fc & ~fd);
        g = 4'(step_r[3:0] * 4'd5 + 4'd1);
      end
      2'd2: begin
        f = fb ^ fc ^ fd;
        g = 4'(step_r[3:0] * 4'd3 + 4'd5);
      end
      default: begin
        f = fc ^ (fb | ~fd);
        g = 4'(step_r[3:0] * 4'd7);
      end
    endcase
    sum = fa + f + md5_k(step_r) + blk_r[g];
    rot = rotl32(sum, md5_rot({rnd, step_r[1:0]}));
  end

  // Sequencer and next-state
  always_comb begin
    logic [5:0] k;
    k          = '0;
    state_nxt  = state_r;
    step_nxt   = step_r;
    chain_nxt  = chain_r;
    work_nxt   = work_r;
    blk_nxt    = blk_r;
    bitcnt_nxt = bitcnt_r;
    fill_nxt   = fill_r;
    last_nxt   = last_r;
    len_nxt    = len_r;
    final_nxt  = final_r;
    idx_nxt    = idx_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_byte_valid) begin
            blk_nxt[fill_r[5:2]][{fill_r[1:0], 3'b000} +: 8] = in_data_byte;
            bitcnt_nxt = bitcnt_r + 64'd8;
            fill_nxt   = fill_r + 6'd1;
            if (fill_r == 6'(BLOCK_BYTES - 1)) begin
              state_nxt = ST_PREP;
              last_nxt  = in_msg_last;
            end else if (in_msg_last) begin
              state_nxt = ST_PAD;
            end
          end else if (in_msg_last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PREP: begin
        work_nxt = chain_r;
        step_nxt = '0;
        state_nxt = ST_COMP;
      end
      ST_COMP: begin
        work_nxt[0] = fd;
        work_nxt[3] = fc;
        work_nxt[2] = fb;
        work_nxt[1] = fb + rot;
        step_nxt    = step_r + 6'd1;
        if (step_r == 6'(BLOCK_BYTES - 1)) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int j = 0; j < 4; j++) begin
          chain_nxt[j] = chain_r[j] + work_r[j];
        end
        if (final_r) begin
          idx_nxt   = '0;
          state_nxt = ST_OUT;
        end else if (len_r) begin
          // length-only block after an overflowing pad
          for (int w = 0; w < BLOCK_WORDS; w++) begin
            blk_nxt[w] = '0;
          end
          blk_nxt[14] = bitcnt_r[31:0];
          blk_nxt[15] = bitcnt_r[63:32];
          len_nxt     = 1'b0;
          final_nxt   = 1'b1;
          state_nxt   = ST_PREP;
        end else if (last_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PAD: begin
        // 0x80 at the fill position, zeros after it
        for (int w = 0; w < BLOCK_WORDS; w++) begin
          for (int b = 0; b < 4; b++) begin
            k = 6'(w * 4 + b);
            if (k == fill_r) begin
              blk_nxt[w][b*8 +: 8] = PAD_BYTE;
            end else if (k > fill_r) begin
              blk_nxt[w][b*8 +: 8] = '0;
            end
          end
        end
        if (fill_r < LEN_POS) begin
          blk_nxt[14] = bitcnt_r[31:0];
          blk_nxt[15] = bitcnt_r[63:32];
          final_nxt   = 1'b1;
        end else begin
          len_nxt = 1'b1;
        end
        last_nxt  = 1'b0;
        state_nxt = ST_PREP;
      end
      ST_OUT: begin
        if (out_ready) begin
          if (idx_r == 2'd3) begin
            chain_nxt[0] = INIT_A;
            chain_nxt[1] = INIT_B;
            chain_nxt[2] = INIT_C;
            chain_nxt[3] = INIT_D;
            bitcnt_nxt   = '0;
            fill_nxt     = '0;
            final_nxt    = 1'b0;
            state_nxt    = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and chaining registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      step_r     <= '0;
      chain_r[0] <= INIT_A;
      chain_r[1] <= INIT_B;
      chain_r[2] <= INIT_C;
      chain_r[3] <= INIT_D;
      bitcnt_r   <= '0;
      fill_r     <= '0;
      last_r     <= 1'b0;
      len_r      <= 1'b0;
      final_r    <= 1'b0;
      idx_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      chain_r  <= chain_nxt;
      bitcnt_r <= bitcnt_nxt;
      fill_r   <= fill_nxt;
      last_r   <= last_nxt;
      len_r    <= len_nxt;
      final_r  <= final_nxt;
      idx_r    <= idx_nxt;
    end
  end

  // Block and working words carry no reset
  always_ff @(posedge clk) begin
    blk_r  <= blk_nxt;
    work_r <= work_nxt;
  end

  // Checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted during digest output");

  a_idx_advance: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_digest_last |=>
      out_valid && (out_word_index == $past(out_word_index) + 2'd1))
    else $error("digest word sequence broken");

  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_digest_last |=>
      (chain_r[0] == INIT_A) && (fill_r == '0) && (bitcnt_r == '0) && in_ready)
    else $error("unit did not re-arm after digest");

  a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_COMP) |-> (step_r == '0))
    else $error("step counter moved outside compression");

endmodule
